// ===== hdl/fiwe_pkg.sv =====
`timescale 1ns / 1ps

package fiwe_pkg;

   localparam int SCALE_FRACTION_BITS = 24;
   localparam logic [31:0] SCALE_RESET = 32'h1 << SCALE_FRACTION_BITS;
   localparam logic [63:0] ROUND_HALF = 64'h1 << (SCALE_FRACTION_BITS - 1);

   localparam int QUEUE_DEPTH = 8;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = QUEUE_PTR_WIDTH + 1;

   typedef logic [QUEUE_PTR_WIDTH-1:0] queue_ptr_type;
   typedef logic [QUEUE_CNT_WIDTH-1:0] queue_cnt_type;

   typedef enum logic [0:0] {
      CSR_SCALE_FACTOR = 1'b0,
      CSR_ORIGIN_TIME  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0] scaled_time;
      logic        first_of_track;
      logic        last_of_track;
   } scaled_item_type;

   typedef struct packed {
      logic stage1_valid;
      logic stage2_valid;
   } front_status_type;

   typedef struct packed {
      logic        pad_after;
      logic [23:0] word_offset;
      logic [15:0] zero_words_before;
      logic [15:0] interval_word;
   } result_type;

endpackage

// ===== hdl/flux_interval_word_encoder_unit.sv =====
`timescale 1ns / 1ps
// path: an accepted req word passes the multiply, round and queue registers to the rsp register
// throughput: one word per cycle unless rsp_tready stalls, set by the interval and error update
// the multiplier and rounding stages feed an 8-entry queue, req_tready drops only when
// the queue count plus the words in the two front stages reach the queue depth
// reset: synchronous, clears the scale to 1.0, origin, time, error and word count

module flux_interval_word_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // transition_time
   input  logic        req_tuser,   // first_of_track
   input  logic        req_tlast,   // last_of_track
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // interval_word, zero_words_before, word_offset
   output logic        rsp_tuser,   // pad_after
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] scale_factor_ff;
   logic [31:0] origin_time_ff;

   fiwe_pkg::scaled_item_type  front_item;
   logic                       front_valid;
   fiwe_pkg::front_status_type front_status;
   fiwe_pkg::scaled_item_type  head_item;
   logic                       head_valid;
   fiwe_pkg::queue_cnt_type    queue_count;
   logic                       pop;
   fiwe_pkg::result_type       result;
   logic [fiwe_pkg::QUEUE_CNT_WIDTH:0] occupancy;
   logic                       accept;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_factor_ff <= fiwe_pkg::SCALE_RESET;
         origin_time_ff  <= '0;
      end else if (csr_valid) begin
         case (fiwe_pkg::csr_index_type'(csr_index))
            fiwe_pkg::CSR_SCALE_FACTOR: begin
               scale_factor_ff <= csr_data;
            end
            fiwe_pkg::CSR_ORIGIN_TIME: begin
               origin_time_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // credit check covers words still in the front stages
   assign occupancy = (fiwe_pkg::QUEUE_CNT_WIDTH + 1)'(queue_count)
                    + (fiwe_pkg::QUEUE_CNT_WIDTH + 1)'(front_status.stage1_valid)
                    + (fiwe_pkg::QUEUE_CNT_WIDTH + 1)'(front_status.stage2_valid);
   assign req_tready = occupancy < (fiwe_pkg::QUEUE_CNT_WIDTH + 1)'(fiwe_pkg::QUEUE_DEPTH);
   assign accept     = req_tvalid && req_tready;

   fiwe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .transition_time (req_tdata),
      .first_of_track  (req_tuser),
      .last_of_track   (req_tlast),
      .scale_factor    (scale_factor_ff),
      .item            (front_item),
      .item_valid      (front_valid),
      .status          (front_status)
   );

   fiwe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .pop       (pop),
      .head_item (head_item),
      .not_empty (head_valid),
      .count     (queue_count)
   );

   fiwe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item        (head_item),
      .item_valid  (head_valid),
      .origin_time (origin_time_ff),
      .rsp_ready   (rsp_tready),
      .pop         (pop),
      .result      (result),
      .rsp_valid   (rsp_tvalid)
   );

   assign rsp_tdata = {result.word_offset, result.zero_words_before, result.interval_word};
   assign rsp_tuser = result.pad_after;

endmodule

// ===== hdl/fiwe_front.sv =====
`timescale 1ns / 1ps

module fiwe_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic [31:0]               transition_time,
   input  logic                      first_of_track,
   input  logic                      last_of_track,
   input  logic [31:0]               scale_factor,
   output fiwe_pkg::scaled_item_type item,
   output logic                      item_valid,
   output fiwe_pkg::front_status_type status
);

   logic [63:0] product_ff;
   logic        first_ff;
   logic        last_ff;
   logic        stage1_valid_ff;

   fiwe_pkg::scaled_item_type item_ff;
   fiwe_pkg::scaled_item_type item_in;
   logic                      stage2_valid_ff;

   logic [63:0] rounded;
   logic [63:0] shifted;

   // multiply stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_valid_ff <= 1'b0;
      end else begin
         stage1_valid_ff <= accept;
      end
      if (accept) begin
         product_ff <= 64'(transition_time) * 64'(scale_factor);
         first_ff   <= first_of_track;
         last_ff    <= last_of_track;
      end
   end

   // round, shift and saturate
   always_comb begin
      rounded = product_ff + fiwe_pkg::ROUND_HALF;
      shifted = rounded >> fiwe_pkg::SCALE_FRACTION_BITS;
      item_in.scaled_time    = (|shifted[63:32]) ? 32'hFFFF_FFFF : shifted[31:0];
      item_in.first_of_track = first_ff;
      item_in.last_of_track  = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage2_valid_ff <= 1'b0;
      end else begin
         stage2_valid_ff <= stage1_valid_ff;
      end
      if (stage1_valid_ff) begin
         item_ff <= item_in;
      end
   end

   assign item       = item_ff;
   assign item_valid = stage2_valid_ff;

   assign status.stage1_valid = stage1_valid_ff;
   assign status.stage2_valid = stage2_valid_ff;

endmodule

// ===== hdl/fiwe_queue.sv =====
`timescale 1ns / 1ps

module fiwe_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  fiwe_pkg::scaled_item_type push_item,
   input  logic                      pop,
   output fiwe_pkg::scaled_item_type head_item,
   output logic                      not_empty,
   output fiwe_pkg::queue_cnt_type   count
);

   fiwe_pkg::scaled_item_type entry_ff [fiwe_pkg::QUEUE_DEPTH];

   fiwe_pkg::queue_ptr_type wr_ptr_ff;
   fiwe_pkg::queue_ptr_type rd_ptr_ff;
   fiwe_pkg::queue_cnt_type count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + fiwe_pkg::queue_ptr_type'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + fiwe_pkg::queue_ptr_type'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + fiwe_pkg::queue_cnt_type'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - fiwe_pkg::queue_cnt_type'(1);
         end
      end
   end

   assign head_item = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

// ===== hdl/fiwe_back.sv =====
`timescale 1ns / 1ps

module fiwe_back (
   input  logic                      clock,
   input  logic                      reset,
   input  fiwe_pkg::scaled_item_type item,
   input  logic                      item_valid,
   input  logic [31:0]               origin_time,
   input  logic                      rsp_ready,
   output logic                      pop,
   output fiwe_pkg::result_type      result,
   output logic                      rsp_valid
);

   logic [31:0] previous_time_ff;
   logic [31:0] push_error_ff;
   logic [23:0] words_emitted_ff;

   logic [31:0] previous_time_in;
   logic [31:0] push_error_in;
   logic [23:0] words_emitted_in;

   fiwe_pkg::result_type result_ff;
   fiwe_pkg::result_type result_in;
   logic                 rsp_valid_ff;

   logic [31:0] prev_time;
   logic [31:0] error;
   logic [23:0] words;
   logic [31:0] raw_interval;
   logic [31:0] interval;
   logic        pushed;
   logic [23:0] words_sum;
   logic        pad;

   assign pop = item_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      prev_time    = item.first_of_track ? origin_time : previous_time_ff;
      error        = item.first_of_track ? 32'd0 : push_error_ff;
      words        = item.first_of_track ? 24'd0 : words_emitted_ff;
      raw_interval = item.scaled_time - prev_time;
      pushed       = raw_interval < (error + 32'd1);
      interval     = pushed ? 32'd1 : raw_interval;
      push_error_in = pushed ? (error + 32'd1 - raw_interval) : error;
      previous_time_in = item.scaled_time;
      words_sum    = words + 24'(interval[31:16]) + 24'd1;
      pad          = item.last_of_track && words_sum[0];
      words_emitted_in = words_sum + 24'(pad);

      result_in.interval_word     = interval[15:0];
      result_in.zero_words_before = interval[31:16];
      result_in.word_offset       = words;
      result_in.pad_after         = pad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_time_ff <= '0;
         push_error_ff    <= '0;
         words_emitted_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (pop) begin
            previous_time_ff <= previous_time_in;
            push_error_ff    <= push_error_in;
            words_emitted_ff <= words_emitted_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff     <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         result_ff <= result_in;
      end
   end

   assign result    = result_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/fiwe_checker.sv =====
`timescale 1ns / 1ps

module fiwe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);

   // pad word only when offset plus codes so far is odd
   a_pad_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[32] == rsp_tdata[16]))
      else $error("pad flagged on even word count");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word present after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("queue not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp word changed");

endmodule

bind flux_interval_word_encoder_unit fiwe_checker u_fiwe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
